[hw/rtl/assert_macros.svh]
// Assertion macros shared by the ACL checker RTL.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition at one edge implies a consequence at the next edge.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/acl_pkg.sv]
// Package for the ACL permission checker: field widths, codes and helpers.
// Used by the channel interfaces, the table cell and the top level.
`timescale 1ns / 1ps

package acl_pkg;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int GRP_W     = 8;
  localparam int OWNER_W   = 8;
  localparam int KIND_W    = 2;
  localparam int MASK_W    = 3;
  localparam int MODE_W    = 9;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 4;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters.
  localparam int TABLE_DEPTH_DEF = 8;
  localparam int ID_BITS_DEF     = 8;

  // Mode register reset value: owner rwx, group r.
  localparam logic [MODE_W-1:0] MODE_RESET = 9'o740;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [MASK_W-1:0]    mask_t;

  // Command codes.
  localparam cmd_t CMD_CHECK  = 2'd0;
  localparam cmd_t CMD_SET    = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  // Access kinds.
  localparam kind_t ACC_READ  = 2'd0;
  localparam kind_t ACC_WRITE = 2'd1;
  localparam kind_t ACC_EXEC  = 2'd2;

  // Status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_OWNER = 2'd0;
  localparam cfg_idx_t CFG_GROUP = 2'd1;
  localparam cfg_idx_t CFG_MODE  = 2'd2;

  // Command broadcast from the top level to every table cell.
  typedef struct packed {
    logic  do_set;
    logic  do_remove;
    logic  any_hit;
    mask_t allow;
    mask_t deny;
  } acl_bcast_t;

  // Picks the rwx bit for an access kind; the unused kind acts as execute.
  function automatic logic kind_bit(input mask_t m, input kind_t kind);
    logic b;
    case (kind)
      ACC_READ:  b = m[2];
      ACC_WRITE: b = m[1];
      default:   b = m[0];
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/acl_if.sv]
// Valid/ready channel interfaces for request and response beats.
// Depends on acl_pkg for the field widths.
`timescale 1ns / 1ps

interface acl_req_if
  import acl_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
);
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ID_BITS-1:0] user_id;
  logic [GRP_W-1:0]  user_group;
  logic [KIND_W-1:0] access_kind;
  logic [MASK_W-1:0] allow_mask;
  logic [MASK_W-1:0] deny_mask;

  modport source (output valid, cmd, user_id, user_group, access_kind, allow_mask,
                  deny_mask, input ready);
  modport sink   (input valid, cmd, user_id, user_group, access_kind, allow_mask,
                  deny_mask, output ready);
endinterface

interface acl_rsp_if
  import acl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [STATUS_W-1:0]  status;
  logic [ENTRIES_W-1:0] entries_used;

  modport source (output valid, granted, status, entries_used, input ready);
  modport sink   (input valid, granted, status, entries_used, output ready);
endinterface

[hw/rtl/acl_permission_checker_top.sv]
// A response beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while the response channel is not stalled; every slot
// matches in parallel in the cell row and a remove shifts the row by one slot in that same cycle.
// Reset (synchronous, rst_n low) empties the table and sets owner 0, group 0, mode 0740.
// No clearing pass is needed; the table is usable as soon as reset is released.
`timescale 1ns / 1ps

module acl_permission_checker_top
  import acl_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  acl_req_if.sink            in_ch,
  acl_rsp_if.source          out_ch,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_idx,
  input  logic [MODE_W-1:0]  cfg_wdata
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [OWNER_W-1:0] owner_r;
  logic [GRP_W-1:0]   group_r;
  logic [MODE_W-1:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
      group_r <= '0;
      mode_r  <= MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OWNER: owner_r <= cfg_wdata[OWNER_W-1:0];
        CFG_GROUP: group_r <= cfg_wdata[GRP_W-1:0];
        CFG_MODE:  mode_r  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Handshake: a new beat is taken whenever the response register is free or draining.
  logic out_valid_r;
  logic fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // Cell row.
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH:0]   seen_vec;
  logic [TABLE_DEPTH-1:0][ID_BITS-1:0] id_vec;
  mask_t [TABLE_DEPTH-1:0] allow_vec;
  mask_t [TABLE_DEPTH-1:0] deny_vec;
  acl_bcast_t bc;
  logic any_hit;
  logic full;

  assign any_hit      = |hit_vec;
  assign full         = valid_vec[TABLE_DEPTH-1];
  assign seen_vec[0]  = 1'b0;
  assign bc.do_set    = fire && (in_ch.cmd == CMD_SET);
  assign bc.do_remove = fire && (in_ch.cmd == CMD_REMOVE);
  assign bc.any_hit   = any_hit;
  assign bc.allow     = in_ch.allow_mask;
  assign bc.deny      = in_ch.deny_mask;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic               prv_valid;
    logic               nxt_valid;
    logic [ID_BITS-1:0] nxt_id;
    mask_t              nxt_allow;
    mask_t              nxt_deny;

    if (i == 0) begin : g_head
      assign prv_valid = 1'b1;
    end else begin : g_body
      assign prv_valid = valid_vec[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nxt_valid = 1'b0;
      assign nxt_id    = '0;
      assign nxt_allow = '0;
      assign nxt_deny  = '0;
    end else begin : g_mid
      assign nxt_valid = valid_vec[i+1];
      assign nxt_id    = id_vec[i+1];
      assign nxt_allow = allow_vec[i+1];
      assign nxt_deny  = deny_vec[i+1];
    end

    acl_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .bc         (bc),
      .uid        (in_ch.user_id),
      .prev_valid (prv_valid),
      .seen_in    (seen_vec[i]),
      .seen_out   (seen_vec[i+1]),
      .nbr_valid  (nxt_valid),
      .nbr_id     (nxt_id),
      .nbr_allow  (nxt_allow),
      .nbr_deny   (nxt_deny),
      .valid      (valid_vec[i]),
      .id         (id_vec[i]),
      .allow      (allow_vec[i]),
      .deny       (deny_vec[i]),
      .hit        (hit_vec[i])
    );
  end

  // Masks of the matching slot; ids are unique, so at most one slot contributes.
  mask_t hit_allow;
  mask_t hit_deny;

  always_comb begin
    hit_allow = '0;
    hit_deny  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_allow = hit_allow | (allow_vec[i] & {MASK_W{hit_vec[i]}});
      hit_deny  = hit_deny  | (deny_vec[i]  & {MASK_W{hit_vec[i]}});
    end
  end

  // Decision and entry count for the beat being accepted.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             granted_c;
  status_t          status_c;
  mask_t            triplet;

  always_comb begin
    if (in_ch.user_id == ID_BITS'(owner_r)) begin
      triplet = mode_r[8:6];
    end else if (in_ch.user_group == group_r) begin
      triplet = mode_r[5:3];
    end else begin
      triplet = mode_r[2:0];
    end
  end

  always_comb begin
    granted_c = 1'b0;
    status_c  = ST_OK;
    count_nxt = count_r;
    unique case (in_ch.cmd)
      CMD_CHECK: begin
        if (kind_bit(hit_deny, in_ch.access_kind)) begin
          granted_c = 1'b0;
        end else if (kind_bit(hit_allow, in_ch.access_kind)) begin
          granted_c = 1'b1;
        end else begin
          granted_c = kind_bit(triplet, in_ch.access_kind);
        end
      end
      CMD_SET: begin
        if (!any_hit) begin
          if (full) begin
            status_c = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (any_hit) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_c = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  // Response register.
  logic                 granted_r;
  status_t              status_r;
  logic [ENTRIES_W-1:0] entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      granted_r <= granted_c;
      status_r  <= status_c;
      entries_r <= ENTRIES_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted      = granted_r;
  assign out_ch.status       = status_r;
  assign out_ch.entries_used = entries_r;

  // The count tracks the number of occupied slots.
  `AST_ALWAYS(a_count_match, $countones(valid_vec) == count_r, "ACL count out of step with slots")
  // A user id never occupies two slots.
  `AST_ALWAYS(a_unique_hit, $onehot0(hit_vec), "ACL user id matched in two slots")
  // Removing an absent user leaves the table as it was.
  `AST_NEXT(a_remove_miss, bc.do_remove && !any_hit, $stable(valid_vec), "ACL remove miss changed table")

endmodule

[hw/rtl/acl_cell.sv]
// One slot of the ACL table: holds a user id with allow and deny masks.
// Depends on acl_pkg; neighbors pass valid, match and entry contents along the row.
`timescale 1ns / 1ps

module acl_cell
  import acl_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  acl_bcast_t         bc,
  input  logic [ID_BITS-1:0] uid,
  input  logic               prev_valid,
  input  logic               seen_in,
  output logic               seen_out,
  input  logic               nbr_valid,
  input  logic [ID_BITS-1:0] nbr_id,
  input  mask_t              nbr_allow,
  input  mask_t              nbr_deny,
  output logic               valid,
  output logic [ID_BITS-1:0] id,
  output mask_t              allow,
  output mask_t              deny,
  output logic               hit
);

  `include "assert_macros.svh"

  logic               valid_r, valid_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  mask_t              allow_r, allow_nxt;
  mask_t              deny_r, deny_nxt;
  logic               shift;
  logic               tail;

  // Match against the requested user, and pass the "match at or before" flag on.
  assign hit      = valid_r && (id_r == uid);
  assign seen_out = seen_in || hit;
  assign shift    = bc.do_remove && bc.any_hit && seen_out;
  assign tail     = prev_valid && !valid_r;

  // Remove pulls the neighbor's entry in; set updates a match or fills the first free slot.
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    allow_nxt = allow_r;
    deny_nxt  = deny_r;
    if (shift) begin
      valid_nxt = nbr_valid;
      id_nxt    = nbr_id;
      allow_nxt = nbr_allow;
      deny_nxt  = nbr_deny;
    end else if (bc.do_set && hit) begin
      allow_nxt = bc.allow;
      deny_nxt  = bc.deny;
    end else if (bc.do_set && !bc.any_hit && tail) begin
      valid_nxt = 1'b1;
      id_nxt    = uid;
      allow_nxt = bc.allow;
      deny_nxt  = bc.deny;
    end
  end

  // Only the valid flag needs a reset; contents are read only while valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    allow_r <= allow_nxt;
    deny_r  <= deny_nxt;
  end

  assign valid = valid_r;
  assign id    = id_r;
  assign allow = allow_r;
  assign deny  = deny_r;

  // Valid slots stay packed at the front of the row.
  `AST_ALWAYS(a_cell_packed, !valid_r || prev_valid, "ACL cell valid behind a free slot")
  // A set that matches this slot leaves it valid.
  `AST_NEXT(a_cell_set_keeps, bc.do_set && hit, valid_r, "ACL cell lost entry on update")
  // A set of a new user into the first free slot makes that slot valid.
  `AST_NEXT(a_cell_fill, bc.do_set && !bc.any_hit && tail, valid_r, "ACL cell fill not taken")

endmodule
